@@ sv/cursor_linked_list_engine_core_macros.svh @@
// ----------------------------------------------------------------------------
// Cursor linked list engine assertion macros
// Shorthand for the implication and next-cycle checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_CORE_MACROS_SVH

`define CLLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cursor list engine check failed");

`define CLLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cursor list engine check failed");

`endif

@@ sv/clle_pkg.sv @@
// ----------------------------------------------------------------------------
// Cursor linked list engine package
// Sizes, request and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package clle_pkg;

	localparam int POOL_NODES = 256;
	localparam int DATA_BITS  = 32;
	localparam int NODE_BITS  = $clog2(POOL_NODES);
	localparam int CNT_BITS   = NODE_BITS + 1;

	typedef enum logic [3:0] {
		REQ_CLEAR      = 4'd0,
		REQ_PREPEND    = 4'd1,
		REQ_APPEND     = 4'd2,
		REQ_INS_BEFORE = 4'd3,
		REQ_INS_AFTER  = 4'd4,
		REQ_DEL_FRONT  = 4'd5,
		REQ_DEL_BACK   = 4'd6,
		REQ_DEL_CURSOR = 4'd7,
		REQ_TO_FRONT   = 4'd8,
		REQ_TO_BACK    = 4'd9,
		REQ_TO_PREV    = 4'd10,
		REQ_TO_NEXT    = 4'd11,
		REQ_SET        = 4'd12,
		REQ_QUERY      = 4'd13
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_FRONT,
		OP_BACK,
		OP_BETWEEN,
		OP_DFRONT,
		OP_DBACK,
		OP_DMID
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD2,
		S_EXEC,
		S_WR2,
		S_V1,
		S_V2,
		S_V3
	} state_t;

endpackage

@@ sv/clle_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/cursor_linked_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// Cursor linked list engine core
// Doubly linked list with a cursor, kept in next, prev and value memories.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload
//  request   start / busy     req_type, value
//  result    done (strobe)    status, list_length, cursor_position,
//                             cursor_value, front_value, back_value
//
// A request runs from acceptance to its done beat through two link
// reads (neighbors, then the free chain), two write steps on the single
// write port of each link memory, and three reads of the value memory.
// busy is high from acceptance until the done beat; a new request may be
// accepted in the cycle of the done beat. Reset empties the list; the node
// memories need no clearing.
module cursor_linked_list_engine_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         req_type,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic [8:0]         list_length,
	output logic signed [8:0]  cursor_position,
	output logic signed [31:0] cursor_value,
	output logic signed [31:0] front_value,
	output logic signed [31:0] back_value
);

	localparam int NB = clle_pkg::NODE_BITS;
	localparam int CB = clle_pkg::CNT_BITS;
	localparam int DB = clle_pkg::DATA_BITS;

	clle_pkg::state_t state_q, state_d;
	logic [3:0]    req_q;
	logic [DB-1:0] val_q;
	logic [NB-1:0] head_q, tail_q, cur_q, cidx_q, fhead_q;
	logic          cdef_q, fvalid_q;
	logic [CB-1:0] cnt_q, wm_q;
	logic [NB-1:0] nxt_q, prv_q;
	logic [1:0]    st_q;
	logic [DB-1:0] hv_q, tv_q;

	logic          nw2_en_q, pw2_en_q;
	logic [NB-1:0] nw2_a_q, nw2_d_q, pw2_a_q, pw2_d_q;

	logic          done_q;
	logic [1:0]    status_q;
	logic [8:0]    len_q;
	logic [8:0]    cpos_q;
	logic [31:0]   cval_q, fval_q, bval_q;

	logic [NB-1:0] d_head, d_tail, d_cur, d_cidx, d_fhead;
	logic          d_cdef, d_fvalid;
	logic [CB-1:0] d_cnt, d_wm;
	logic [1:0]    d_st;
	logic          nw1_en, nw2_en, pw1_en, pw2_en, vw_en;
	logic [NB-1:0] nw1_a, nw1_d, nw2_a, nw2_d, pw1_a, pw1_d, pw2_a, pw2_d, vw_a;

	logic          n_we, p_we;
	logic [NB-1:0] n_wa, n_wd, p_wa, p_wd, n_ra, p_ra, v_ra;
	logic [NB-1:0] n_rd, p_rd;
	logic [DB-1:0] v_rd;

	clle_ram #(.WIDTH(NB), .DEPTH(clle_pkg::POOL_NODES)) u_next (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
	);

	clle_ram #(.WIDTH(NB), .DEPTH(clle_pkg::POOL_NODES)) u_prev (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
	);

	clle_ram #(.WIDTH(DB), .DEPTH(clle_pkg::POOL_NODES)) u_value (
		.clk(clk), .we(vw_en), .waddr(vw_a), .wdata(val_q), .raddr(v_ra), .rdata(v_rd)
	);

	assign busy = (state_q != clle_pkg::S_IDLE);

	always_comb begin
		n_ra = cur_q;
		p_ra = cur_q;
		v_ra = cur_q;
		if (state_q == clle_pkg::S_IDLE) begin
			if (req_type == clle_pkg::REQ_DEL_FRONT) begin
				n_ra = head_q;
			end
			if (req_type == clle_pkg::REQ_DEL_BACK) begin
				p_ra = tail_q;
			end
		end else if (state_q == clle_pkg::S_RD2) begin
			n_ra = fhead_q;
		end
		if (state_q == clle_pkg::S_WR2) begin
			v_ra = head_q;
		end else if (state_q == clle_pkg::S_V1) begin
			v_ra = tail_q;
		end
	end

	always_comb begin
		n_we = 1'b0;
		n_wa = nw1_a;
		n_wd = nw1_d;
		p_we = 1'b0;
		p_wa = pw1_a;
		p_wd = pw1_d;
		if (state_q == clle_pkg::S_EXEC) begin
			n_we = nw1_en;
			p_we = pw1_en;
		end else if (state_q == clle_pkg::S_WR2) begin
			n_we = nw2_en_q;
			n_wa = nw2_a_q;
			n_wd = nw2_d_q;
			p_we = pw2_en_q;
			p_wa = pw2_a_q;
			p_wd = pw2_d_q;
		end
	end

	always_comb begin
		clle_pkg::op_t op;
		logic [NB-1:0] ba, bb, tn;
		logic          tok, at_last;
		op = clle_pkg::OP_NONE;
		ba = cur_q;
		bb = cur_q;
		tok = fvalid_q || (wm_q < CB'(clle_pkg::POOL_NODES));
		tn = fvalid_q ? fhead_q : wm_q[NB-1:0];
		at_last = ({1'b0, cidx_q} == cnt_q - CB'(1));
		d_head = head_q;
		d_tail = tail_q;
		d_cur = cur_q;
		d_cidx = cidx_q;
		d_cdef = cdef_q;
		d_cnt = cnt_q;
		d_fhead = fhead_q;
		d_fvalid = fvalid_q;
		d_wm = wm_q;
		d_st = clle_pkg::ST_DONE;
		nw1_en = 1'b0;
		nw1_a = tn;
		nw1_d = head_q;
		nw2_en = 1'b0;
		nw2_a = tn;
		nw2_d = tn;
		pw1_en = 1'b0;
		pw1_a = tn;
		pw1_d = tn;
		pw2_en = 1'b0;
		pw2_a = tn;
		pw2_d = tn;
		vw_en = 1'b0;
		vw_a = tn;

		case (req_q)
			clle_pkg::REQ_CLEAR: begin
				d_head = '0;
				d_tail = '0;
				d_cur = '0;
				d_cidx = '0;
				d_cdef = 1'b0;
				d_cnt = '0;
				d_fhead = '0;
				d_fvalid = 1'b0;
				d_wm = '0;
			end
			clle_pkg::REQ_PREPEND: op = clle_pkg::OP_FRONT;
			clle_pkg::REQ_APPEND: op = clle_pkg::OP_BACK;
			clle_pkg::REQ_INS_BEFORE: begin
				if (cnt_q == '0) begin
					op = clle_pkg::OP_FRONT;
				end else if (!cdef_q) begin
					d_st = clle_pkg::ST_IGNORED;
				end else if (cidx_q == '0) begin
					op = clle_pkg::OP_FRONT;
				end else begin
					op = clle_pkg::OP_BETWEEN;
					ba = prv_q;
					bb = cur_q;
				end
			end
			clle_pkg::REQ_INS_AFTER: begin
				if (cnt_q == '0) begin
					op = clle_pkg::OP_BACK;
				end else if (!cdef_q) begin
					d_st = clle_pkg::ST_IGNORED;
				end else if (at_last) begin
					op = clle_pkg::OP_BACK;
				end else begin
					op = clle_pkg::OP_BETWEEN;
					ba = cur_q;
					bb = nxt_q;
				end
			end
			clle_pkg::REQ_DEL_FRONT: op = clle_pkg::OP_DFRONT;
			clle_pkg::REQ_DEL_BACK: op = clle_pkg::OP_DBACK;
			clle_pkg::REQ_DEL_CURSOR: begin
				if (cnt_q == '0 || !cdef_q) begin
					d_st = clle_pkg::ST_IGNORED;
				end else if (cidx_q == '0) begin
					op = clle_pkg::OP_DFRONT;
				end else if (at_last) begin
					op = clle_pkg::OP_DBACK;
				end else begin
					op = clle_pkg::OP_DMID;
				end
			end
			clle_pkg::REQ_TO_FRONT: begin
				if (cnt_q == '0) begin
					d_st = clle_pkg::ST_IGNORED;
				end else begin
					d_cur = head_q;
					d_cidx = '0;
					d_cdef = 1'b1;
				end
			end
			clle_pkg::REQ_TO_BACK: begin
				if (cnt_q == '0) begin
					d_st = clle_pkg::ST_IGNORED;
				end else begin
					d_cur = tail_q;
					d_cidx = NB'(cnt_q - CB'(1));
					d_cdef = 1'b1;
				end
			end
			clle_pkg::REQ_TO_PREV: begin
				if (!cdef_q || cnt_q == '0) begin
					d_st = clle_pkg::ST_IGNORED;
				end else if (cidx_q == '0) begin
					d_cdef = 1'b0;
				end else begin
					d_cur = prv_q;
					d_cidx = cidx_q - NB'(1);
				end
			end
			clle_pkg::REQ_TO_NEXT: begin
				if (!cdef_q || cnt_q == '0) begin
					d_st = clle_pkg::ST_IGNORED;
				end else if ({1'b0, cidx_q} >= cnt_q - CB'(1)) begin
					d_cdef = 1'b0;
				end else begin
					d_cur = nxt_q;
					d_cidx = cidx_q + NB'(1);
				end
			end
			clle_pkg::REQ_SET: begin
				if (!cdef_q || cnt_q == '0) begin
					d_st = clle_pkg::ST_IGNORED;
				end else begin
					vw_en = 1'b1;
					vw_a = cur_q;
				end
			end
			default: ;
		endcase

		case (op)
			clle_pkg::OP_FRONT, clle_pkg::OP_BACK, clle_pkg::OP_BETWEEN: begin
				if (!tok) begin
					d_st = clle_pkg::ST_FULL;
				end else begin
					if (fvalid_q) begin
						d_fhead = n_rd;
						d_fvalid = (wm_q - cnt_q) > CB'(1);
					end else begin
						d_wm = wm_q + CB'(1);
					end
					vw_en = 1'b1;
					vw_a = tn;
					d_cnt = cnt_q + CB'(1);
					if (op == clle_pkg::OP_BETWEEN) begin
						nw1_en = 1'b1;
						nw1_a = tn;
						nw1_d = bb;
						nw2_en = 1'b1;
						nw2_a = ba;
						nw2_d = tn;
						pw1_en = 1'b1;
						pw1_a = tn;
						pw1_d = ba;
						pw2_en = 1'b1;
						pw2_a = bb;
						pw2_d = tn;
						if (req_q == clle_pkg::REQ_INS_BEFORE) begin
							d_cidx = cidx_q + NB'(1);
						end
					end else if (cnt_q == '0) begin
						d_head = tn;
						d_tail = tn;
					end else if (op == clle_pkg::OP_FRONT) begin
						nw1_en = 1'b1;
						nw1_a = tn;
						nw1_d = head_q;
						pw1_en = 1'b1;
						pw1_a = head_q;
						pw1_d = tn;
						d_head = tn;
					end else begin
						nw1_en = 1'b1;
						nw1_a = tail_q;
						nw1_d = tn;
						pw1_en = 1'b1;
						pw1_a = tn;
						pw1_d = tail_q;
						d_tail = tn;
					end
					if (op == clle_pkg::OP_FRONT && cdef_q) begin
						d_cidx = cidx_q + NB'(1);
					end
				end
			end
			clle_pkg::OP_DFRONT, clle_pkg::OP_DBACK: begin
				if (cnt_q == '0) begin
					d_st = clle_pkg::ST_IGNORED;
				end else begin
					nw1_en = 1'b1;
					nw1_a = (op == clle_pkg::OP_DFRONT) ? head_q : tail_q;
					nw1_d = fhead_q;
					d_fhead = nw1_a;
					d_fvalid = 1'b1;
					d_cnt = cnt_q - CB'(1);
					if (cnt_q == CB'(1)) begin
						d_cdef = 1'b0;
					end else if (op == clle_pkg::OP_DFRONT) begin
						d_head = nxt_q;
						if (cdef_q) begin
							if (cidx_q == '0) begin
								d_cdef = 1'b0;
							end else begin
								d_cidx = cidx_q - NB'(1);
							end
						end
					end else begin
						d_tail = prv_q;
						if (cdef_q && at_last) begin
							d_cdef = 1'b0;
						end
					end
				end
			end
			clle_pkg::OP_DMID: begin
				nw1_en = 1'b1;
				nw1_a = prv_q;
				nw1_d = nxt_q;
				pw1_en = 1'b1;
				pw1_a = nxt_q;
				pw1_d = prv_q;
				nw2_en = 1'b1;
				nw2_a = cur_q;
				nw2_d = fhead_q;
				d_fhead = cur_q;
				d_fvalid = 1'b1;
				d_cnt = cnt_q - CB'(1);
				d_cdef = 1'b0;
			end
			default: ;
		endcase

		if (d_cnt == '0) begin
			d_cdef = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			clle_pkg::S_IDLE: if (start) state_d = clle_pkg::S_RD2;
			clle_pkg::S_RD2: state_d = clle_pkg::S_EXEC;
			clle_pkg::S_EXEC: state_d = clle_pkg::S_WR2;
			clle_pkg::S_WR2: state_d = clle_pkg::S_V1;
			clle_pkg::S_V1: state_d = clle_pkg::S_V2;
			clle_pkg::S_V2: state_d = clle_pkg::S_V3;
			clle_pkg::S_V3: state_d = clle_pkg::S_IDLE;
			default: state_d = clle_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clle_pkg::S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			cur_q <= '0;
			cidx_q <= '0;
			cdef_q <= 1'b0;
			cnt_q <= '0;
			fhead_q <= '0;
			fvalid_q <= 1'b0;
			wm_q <= '0;
			nw2_en_q <= 1'b0;
			pw2_en_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == clle_pkg::S_V3);
			if (state_q == clle_pkg::S_EXEC) begin
				head_q <= d_head;
				tail_q <= d_tail;
				cur_q <= d_cur;
				cidx_q <= d_cidx;
				cdef_q <= d_cdef;
				cnt_q <= d_cnt;
				fhead_q <= d_fhead;
				fvalid_q <= d_fvalid;
				wm_q <= d_wm;
				nw2_en_q <= nw2_en;
				pw2_en_q <= pw2_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == clle_pkg::S_IDLE && start) begin
			req_q <= req_type;
			val_q <= value;
		end
		if (state_q == clle_pkg::S_RD2) begin
			nxt_q <= n_rd;
			prv_q <= p_rd;
		end
		if (state_q == clle_pkg::S_EXEC) begin
			st_q <= d_st;
			nw2_a_q <= nw2_a;
			nw2_d_q <= nw2_d;
			pw2_a_q <= pw2_a;
			pw2_d_q <= pw2_d;
		end
		if (state_q == clle_pkg::S_V1) begin
			hv_q <= v_rd;
		end
		if (state_q == clle_pkg::S_V2) begin
			tv_q <= v_rd;
		end
		if (state_q == clle_pkg::S_V3) begin
			status_q <= st_q;
			len_q <= cnt_q;
			cpos_q <= cdef_q ? {1'b0, cidx_q} : '1;
			cval_q <= cdef_q ? v_rd : '1;
			fval_q <= (cnt_q != '0) ? hv_q : '1;
			bval_q <= (cnt_q != '0) ? tv_q : '1;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign list_length = len_q;
	assign cursor_position = cpos_q;
	assign cursor_value = cval_q;
	assign front_value = fval_q;
	assign back_value = bval_q;

endmodule

@@ sv/clle_chk.sv @@
// ----------------------------------------------------------------------------
// Cursor linked list engine checker
// Port-level checks on the request and result beats.
// ----------------------------------------------------------------------------
`include "cursor_linked_list_engine_core_macros.svh"

module clle_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [8:0]  list_length,
	input logic [8:0]  cursor_position
);

	`CLLE_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`CLLE_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`CLLE_ASSERT_IMP(a_len_range, clk, arst_n, done, list_length <= 9'd256 && status != 2'd3)
	`CLLE_ASSERT_IMP(a_empty_cursor, clk, arst_n, done && list_length == 9'd0,
		cursor_position == 9'h1FF)
	`CLLE_ASSERT_IMP(a_cursor_in_list, clk, arst_n, done && cursor_position != 9'h1FF,
		cursor_position < list_length)

endmodule

bind cursor_linked_list_engine_core clle_chk u_clle_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.list_length(list_length),
	.cursor_position(cursor_position)
);
